// ===== hw/rtl/fsme_pkg.sv =====
package fsme_pkg;

  localparam int MaxStates  = 16;
  localparam int MaxTrans   = 64;
  localparam int SigBits    = 8;

  localparam int StateW     = $clog2(MaxStates);
  localparam int StateCntW  = $clog2(MaxStates + 1);
  localparam int EdgeAddrW  = $clog2(MaxTrans);
  localparam int TransCntW  = $clog2(MaxTrans + 1);
  localparam int IdW        = 6;

  localparam logic [1:0] CMD_ADD_STATE = 2'd0;
  localparam logic [1:0] CMD_ADD_TRANS = 2'd1;
  localparam logic [1:0] CMD_SET_STATE = 2'd2;
  localparam logic [1:0] CMD_SIGNAL    = 2'd3;

  typedef struct packed {
    logic [StateW-1:0]  dst;
    logic [StateW-1:0]  src;
    logic [SigBits-1:0] sig;
  } edge_t;

  localparam int EdgeW = $bits(edge_t);

endpackage

// ===== hw/rtl/fsme_ram.sv =====
module fsme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/table_driven_fsm_engine.sv =====
// Channel   Dir  Width  Contents
// s_*       in   24     item: cmd, state_a, state_b, signal_value, accept_flag
// m_*       out  32     result: status, new_id, current_state, current_valid,
//                       in_accept, state_count, transition_count
// cfg_*     in   8      fallback signal register write
//
// An item with no table walk goes to FINISH, then EMIT, which registers its m_tdata result.
// Add transition and deliver signal walk the edge RAM one entry a cycle through its
// registered read port until a match or the end of the table.
// One item is in flight at a time; s_tready is low until its result is registered.
// A stalled result holds the next item in its last step until the result is taken.
// rst is synchronous; after it the machine has no states and the fallback signal is 255.
module table_driven_fsm_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] cmd, [5:2] state_a, [9:6] state_b, [17:10] signal_value,
  // [18] accept_flag, [23:19] zero
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] status, [6:1] new_id, [10:7] current_state, [11] current_valid,
  // [12] in_accept, [17:13] state_count, [24:18] transition_count, [31:25] zero
  output logic [31:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import fsme_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]           st;
  logic [SigBits-1:0]   fallback_sig;

  logic [StateW-1:0]    cur;
  logic                 present;
  logic [StateCntW-1:0] states_used;
  logic [TransCntW-1:0] trans_used;
  logic [MaxStates-1:0] accept_marks;
  logic [MaxStates-1:0] fb_valid;
  logic [StateW-1:0]    fb_dst [MaxStates];

  // latched item
  logic [1:0]           cmd;
  logic [StateW-1:0]    a;
  logic [StateW-1:0]    b;
  logic [SigBits-1:0]   sig;
  logic                 acc;
  logic                 ok;
  logic [StateW-1:0]    key;

  logic [TransCntW-1:0] idx;
  logic                 rd_valid;
  logic                 hit;
  logic [StateW-1:0]    hit_dst;
  logic                 status;
  logic [IdW-1:0]       new_id;
  logic                 status_next;
  logic [IdW-1:0]       new_id_next;

  logic                 ram_we;
  edge_t                ram_wdata;
  edge_t                ram_rdata;
  logic                 issue;
  logic                 match;

  logic [1:0]           in_cmd;
  logic [StateW-1:0]    in_a;
  logic [StateW-1:0]    in_b;
  logic                 in_ok;
  logic                 in_scan;

  assign in_cmd = s_tdata[1:0];
  assign in_a   = s_tdata[5:2];
  assign in_b   = s_tdata[9:6];

  assign in_ok = ({1'b0, in_a} < states_used) && ({1'b0, in_b} < states_used) &&
                 (trans_used < TransCntW'(MaxTrans));
  assign in_scan = ((in_cmd == CMD_ADD_TRANS) && in_ok) ||
                   ((in_cmd == CMD_SIGNAL) && present);

  assign s_tready = (st == ST_IDLE);

  assign issue = (idx < trans_used);
  assign match = rd_valid && (ram_rdata.src == key) && (ram_rdata.sig == sig);

  assign ram_we        = (st == ST_FINISH) && (cmd == CMD_ADD_TRANS) && ok && !hit;
  assign ram_wdata.dst = b;
  assign ram_wdata.src = a;
  assign ram_wdata.sig = sig;

  fsme_ram #(
    .WIDTH (EdgeW),
    .DEPTH (MaxTrans)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (trans_used[EdgeAddrW-1:0]),
    .wdata (ram_wdata),
    .raddr (idx[EdgeAddrW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_sig <= '1;
    end else if (cfg_wr_en) begin
      fallback_sig <= cfg_wr_data[SigBits-1:0];
    end
  end

  always_comb begin
    status_next = 1'b1;
    new_id_next = '0;
    case (cmd)
      CMD_ADD_STATE: begin
        if (states_used < StateCntW'(MaxStates)) begin
          status_next = 1'b0;
          new_id_next = IdW'(states_used);
        end
      end
      CMD_ADD_TRANS: begin
        if (ok && !hit) begin
          status_next = 1'b0;
          new_id_next = IdW'(trans_used);
        end
      end
      CMD_SET_STATE: begin
        if ({1'b0, a} < states_used) begin
          status_next = 1'b0;
        end
      end
      default: begin
        if (present && (hit || fb_valid[cur])) begin
          status_next = 1'b0;
        end
      end
    endcase
  end

  // control and machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      cur         <= '0;
      present     <= 1'b0;
      states_used <= '0;
      trans_used  <= '0;
      fb_valid    <= '0;
      idx         <= '0;
      rd_valid    <= 1'b0;
      hit         <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if ((st == ST_EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            idx      <= '0;
            rd_valid <= 1'b0;
            hit      <= 1'b0;
            st       <= in_scan ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (match) begin
            hit      <= 1'b1;
            rd_valid <= 1'b0;
            st       <= ST_FINISH;
          end else if (!issue && !rd_valid) begin
            st <= ST_FINISH;
          end else begin
            idx      <= idx + TransCntW'(issue);
            rd_valid <= issue;
          end
        end
        ST_FINISH: begin
          case (cmd)
            CMD_ADD_STATE: begin
              if (states_used < StateCntW'(MaxStates)) begin
                fb_valid[states_used[StateW-1:0]] <= 1'b0;
                states_used <= states_used + StateCntW'(1);
                if (states_used == '0) begin
                  cur     <= '0;
                  present <= 1'b1;
                end
              end
            end
            CMD_ADD_TRANS: begin
              if (ok && !hit) begin
                trans_used <= trans_used + TransCntW'(1);
                if (sig == fallback_sig) begin
                  fb_valid[a] <= 1'b1;
                end
              end
            end
            CMD_SET_STATE: begin
              if ({1'b0, a} < states_used) begin
                cur <= a;
              end
            end
            default: begin
              if (present) begin
                if (hit) begin
                  cur <= hit_dst;
                end else if (fb_valid[cur]) begin
                  cur <= fb_dst[cur];
                end
              end
            end
          endcase
          st <= ST_EMIT;
        end
        default: begin
          // hold until the previous result has been taken
          if (!m_tvalid || m_tready) begin
            st <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((st == ST_IDLE) && s_tvalid) begin
      cmd <= in_cmd;
      a   <= in_a;
      b   <= in_b;
      sig <= s_tdata[10 +: SigBits];
      acc <= s_tdata[18];
      ok  <= in_ok;
      key <= (in_cmd == CMD_SIGNAL) ? cur : in_a;
    end
    if ((st == ST_SCAN) && match) begin
      hit_dst <= ram_rdata.dst;
    end
    if (st == ST_FINISH) begin
      status <= status_next;
      new_id <= new_id_next;
      if ((cmd == CMD_ADD_STATE) && (states_used < StateCntW'(MaxStates))) begin
        accept_marks[states_used[StateW-1:0]] <= acc;
      end
      if ((cmd == CMD_ADD_TRANS) && ok && !hit && (sig == fallback_sig)) begin
        fb_dst[a] <= b;
      end
    end
    if ((st == ST_EMIT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, trans_used, states_used, present && accept_marks[cur],
                  present, present ? cur : StateW'(0), new_id, status};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (trans_used <= TransCntW'(MaxTrans)) && (states_used <= StateCntW'(MaxStates)))
    else $error("table counts beyond capacity");

  a_current_exists: assert property (@(posedge clk) disable iff (rst)
    present |-> ({1'b0, cur} < states_used))
    else $error("current state not among added states");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(st == ST_EMIT))
    else $error("result raised outside the emit step");

endmodule
